FILE: rtl/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared widths, function codes, defaults and types for the knob pickup block.
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int NUM_KNOBS_DEF = 8;
    localparam int NUM_PAGES_DEF = 2;

    localparam int FUNC_W  = 2;
    localparam int KNOB_W  = 3;
    localparam int PAGE_W  = 1;
    localparam int VALUE_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SWITCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd2;

    localparam logic [VALUE_W-1:0] WINDOW_RESET = 16'd1311;

    typedef struct packed {
        logic locked;
        logic apply;
    } pickup_t;

endpackage

FILE: rtl/knob_pickup_catch.sv
// ----------------------------------------------------------------------------
// knob_pickup_catch
// Soft takeover for a bank of knobs over several parameter pages.
// ----------------------------------------------------------------------------
// Each accepted beat is registered in the input stage and its result in the output stage.
// Throughput: one beat per cycle while out_ready does not stall the output; all state lives
// in flops and each item reads and writes one entry (a page switch relocks every knob of its
// page) through a single combinational update stage. Reset clears all stored values and
// readings, locks every knob, selects page zero and loads the default catch window.
module knob_pickup_catch
#(
    parameter int NUM_KNOBS = kpc_pkg::NUM_KNOBS_DEF,
    parameter int NUM_PAGES = kpc_pkg::NUM_PAGES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [kpc_pkg::VALUE_W-1:0] cfg_data,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [kpc_pkg::FUNC_W-1:0]  func,
    input  logic [kpc_pkg::KNOB_W-1:0]  knob_index,
    input  logic [kpc_pkg::PAGE_W-1:0]  page_select,
    input  logic [kpc_pkg::VALUE_W-1:0] knob_value,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [kpc_pkg::PAGE_W-1:0]  out_page,
    output logic [kpc_pkg::KNOB_W-1:0]  out_knob,
    output logic                        applied,
    output logic [kpc_pkg::VALUE_W-1:0] stored_value,
    output logic                        is_locked
);

    localparam int ENTRIES = NUM_KNOBS * NUM_PAGES;
    localparam int EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic                        s1_valid_reg;
    logic [kpc_pkg::FUNC_W-1:0]  func_reg;
    logic [kpc_pkg::KNOB_W-1:0]  knob_reg;
    logic [kpc_pkg::PAGE_W-1:0]  psel_reg;
    logic [kpc_pkg::VALUE_W-1:0] value_reg;

    logic                        out_valid_reg;
    logic [kpc_pkg::PAGE_W-1:0]  out_page_reg;
    logic [kpc_pkg::KNOB_W-1:0]  out_knob_reg;
    logic                        applied_reg;
    logic [kpc_pkg::VALUE_W-1:0] stored_value_reg;
    logic                        is_locked_reg;

    logic [kpc_pkg::VALUE_W-1:0] window_reg;
    logic [kpc_pkg::PAGE_W-1:0]  cur_page_reg;
    logic [kpc_pkg::PAGE_W-1:0]  cur_page_next;

    logic [kpc_pkg::VALUE_W-1:0] stored_reg  [ENTRIES];
    logic [kpc_pkg::VALUE_W-1:0] stored_next [ENTRIES];
    logic [kpc_pkg::VALUE_W-1:0] last_reg    [ENTRIES];
    logic [kpc_pkg::VALUE_W-1:0] last_next   [ENTRIES];
    logic [ENTRIES-1:0]          lock_reg;
    logic [ENTRIES-1:0]          lock_next;

    logic                        s1_fire;
    logic                        knob_ok;
    logic                        psel_ok;
    logic [kpc_pkg::PAGE_W-1:0]  rd_page;
    logic                        rd_ok;
    logic [EW-1:0]               rd_idx;
    logic [EW-1:0]               sw_idx;
    logic [kpc_pkg::VALUE_W-1:0] rd_stored;
    logic [kpc_pkg::VALUE_W-1:0] rd_last;
    logic                        rd_lock;
    kpc_pkg::pickup_t            pick;

    logic                        applied_next;
    logic [kpc_pkg::VALUE_W-1:0] stored_value_next;
    logic                        is_locked_next;

    assign cfg_ready = 1'b1;
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_fire;

    assign knob_ok = int'(knob_reg) < NUM_KNOBS;
    assign psel_ok = int'(psel_reg) < NUM_PAGES;

    always_comb
    begin
        case (func_reg)
            kpc_pkg::FUNC_SWITCH:
            begin
                rd_page = psel_ok ? psel_reg : cur_page_reg;
            end
            kpc_pkg::FUNC_SET:
            begin
                rd_page = psel_reg;
            end
            default:
            begin
                rd_page = cur_page_reg;
            end
        endcase
        rd_ok  = knob_ok && (int'(rd_page) < NUM_PAGES);
        rd_idx = EW'(int'(rd_page) * NUM_KNOBS + int'(knob_reg));
    end

    always_comb
    begin
        rd_stored = '0;
        rd_last   = '0;
        rd_lock   = 1'b1;
        if (rd_ok)
        begin
            rd_stored = stored_reg[rd_idx];
            rd_last   = last_reg[rd_idx];
            rd_lock   = lock_reg[rd_idx];
        end
    end

    kpc_pickup u_pickup
    (
        .stored  (rd_stored),
        .prev    (rd_last),
        .locked  (rd_lock),
        .reading (value_reg),
        .window  (window_reg),
        .result  (pick)
    );

    always_comb
    begin
        stored_next       = stored_reg;
        last_next         = last_reg;
        lock_next         = lock_reg;
        cur_page_next     = cur_page_reg;
        applied_next      = 1'b0;
        stored_value_next = rd_ok ? rd_stored : '0;
        is_locked_next    = rd_ok ? rd_lock : 1'b1;
        sw_idx            = '0;

        case (func_reg)
            kpc_pkg::FUNC_SAMPLE:
            begin
                if (rd_ok)
                begin
                    last_next[rd_idx] = value_reg;
                    lock_next[rd_idx] = pick.locked;
                    is_locked_next    = pick.locked;
                    if (pick.apply)
                    begin
                        stored_next[rd_idx] = value_reg;
                        stored_value_next   = value_reg;
                        applied_next        = 1'b1;
                    end
                end
            end
            kpc_pkg::FUNC_SWITCH:
            begin
                if (psel_ok)
                begin
                    for (int k = 0; k < NUM_KNOBS; k++)
                    begin
                        sw_idx            = EW'(int'(psel_reg) * NUM_KNOBS + k);
                        lock_next[sw_idx] = 1'b1;
                    end
                    cur_page_next  = psel_reg;
                    is_locked_next = 1'b1;
                end
            end
            kpc_pkg::FUNC_SET:
            begin
                if (rd_ok)
                begin
                    stored_next[rd_idx] = value_reg;
                    lock_next[rd_idx]   = 1'b1;
                    stored_value_next   = value_reg;
                    is_locked_next      = 1'b1;
                end
            end
            default:
            begin
                applied_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= kpc_pkg::WINDOW_RESET;
        end
        else if (cfg_valid)
        begin
            window_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg  <= func;
            knob_reg  <= knob_index;
            psel_reg  <= page_select;
            value_reg <= knob_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_page_reg <= '0;
            lock_reg     <= '1;
            for (int i = 0; i < ENTRIES; i++)
            begin
                stored_reg[i] <= '0;
                last_reg[i]   <= '0;
            end
        end
        else if (s1_fire)
        begin
            cur_page_reg <= cur_page_next;
            lock_reg     <= lock_next;
            stored_reg   <= stored_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_page_reg     <= cur_page_next;
            out_knob_reg     <= knob_reg;
            applied_reg      <= applied_next;
            stored_value_reg <= stored_value_next;
            is_locked_reg    <= is_locked_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_page     = out_page_reg;
    assign out_knob     = out_knob_reg;
    assign applied      = applied_reg;
    assign stored_value = stored_value_reg;
    assign is_locked    = is_locked_reg;

endmodule

FILE: rtl/kpc_pickup.sv
// ----------------------------------------------------------------------------
// kpc_pickup
// Catch decision for one knob: unlocks on a crossing or inside the window.
// ----------------------------------------------------------------------------
module kpc_pickup
(
    input  logic [kpc_pkg::VALUE_W-1:0] stored,
    input  logic [kpc_pkg::VALUE_W-1:0] prev,
    input  logic                        locked,
    input  logic [kpc_pkg::VALUE_W-1:0] reading,
    input  logic [kpc_pkg::VALUE_W-1:0] window,
    output kpc_pkg::pickup_t            result
);

    logic [kpc_pkg::VALUE_W-1:0] distance;
    logic                        crossed;

    always_comb
    begin
        if (reading >= stored)
        begin
            distance = reading - stored;
        end
        else
        begin
            distance = stored - reading;
        end
        crossed = ((prev <= stored) && (reading >= stored)) ||
                  ((prev >= stored) && (reading <= stored)) ||
                  (distance < window);
        result.locked = locked && !crossed;
        result.apply  = !result.locked && (stored != reading);
    end

endmodule

FILE: sim/knob_pickup_catch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_pickup_catch_checker
// Watches the configuration, input and result channels of the knob pickup
// block, keeps its own copy of every page's stored values, readings and lock
// flags, and compares each result beat field by field with the prediction.
// ----------------------------------------------------------------------------
module knob_pickup_catch_checker
#(
    parameter int NUM_KNOBS = kpc_pkg::NUM_KNOBS_DEF,
    parameter int NUM_PAGES = kpc_pkg::NUM_PAGES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [kpc_pkg::VALUE_W-1:0] cfg_data,

    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [kpc_pkg::FUNC_W-1:0]  func,
    input  logic [kpc_pkg::KNOB_W-1:0]  knob_index,
    input  logic [kpc_pkg::PAGE_W-1:0]  page_select,
    input  logic [kpc_pkg::VALUE_W-1:0] knob_value,

    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [kpc_pkg::PAGE_W-1:0]  out_page,
    input  logic [kpc_pkg::KNOB_W-1:0]  out_knob,
    input  logic                        applied,
    input  logic [kpc_pkg::VALUE_W-1:0] stored_value,
    input  logic                        is_locked,

    output int                          mismatches,
    output int                          outstanding
);

    localparam int ENTRIES     = NUM_KNOBS * NUM_PAGES;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [kpc_pkg::PAGE_W-1:0]  page;
        logic [kpc_pkg::KNOB_W-1:0]  knob;
        logic                        applied;
        logic [kpc_pkg::VALUE_W-1:0] value;
        logic                        locked;
    } pickup_result_t;

    logic [kpc_pkg::VALUE_W-1:0] stored_vals [ENTRIES];
    logic [kpc_pkg::VALUE_W-1:0] last_reads [ENTRIES];
    logic                        lock_bits [ENTRIES];
    int unsigned                 cur_page;
    logic [kpc_pkg::VALUE_W-1:0] catch_window;
    pickup_result_t              pending_results [$];
    int                          results_seen;

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
        begin
            $display("%0t: result %0d: %s is %0h, predicted %0h", $realtime, results_seen,
                     what, got, want);
        end
    endtask

    function automatic pickup_result_t takeover_step(
        input logic [kpc_pkg::FUNC_W-1:0]  op,
        input logic [kpc_pkg::KNOB_W-1:0]  knob,
        input logic [kpc_pkg::PAGE_W-1:0]  psel,
        input logic [kpc_pkg::VALUE_W-1:0] reading
    );
        int unsigned                 kn;
        int unsigned                 ps;
        int unsigned                 report_page;
        int unsigned                 e;
        int unsigned                 j;
        logic [kpc_pkg::VALUE_W-1:0] s;
        logic [kpc_pkg::VALUE_W-1:0] prev;
        logic [kpc_pkg::VALUE_W-1:0] distance;
        pickup_result_t              r;

        kn = knob;
        ps = psel;
        report_page = cur_page;
        r.applied = 1'b0;
        case (op)
            kpc_pkg::FUNC_SAMPLE:
            begin
                if (kn < NUM_KNOBS && cur_page < NUM_PAGES)
                begin
                    e = cur_page * NUM_KNOBS + kn;
                    s = stored_vals[e];
                    prev = last_reads[e];
                    if (lock_bits[e])
                    begin
                        distance = (reading >= s) ? reading - s : s - reading;
                        if ((prev <= s && reading >= s) || (prev >= s && reading <= s)
                            || distance < catch_window)
                        begin
                            lock_bits[e] = 1'b0;
                        end
                    end
                    last_reads[e] = reading;
                    if (!lock_bits[e] && s != reading)
                    begin
                        stored_vals[e] = reading;
                        r.applied = 1'b1;
                    end
                end
            end
            kpc_pkg::FUNC_SWITCH:
            begin
                if (ps < NUM_PAGES)
                begin
                    for (j = 0; j < NUM_KNOBS; j++)
                    begin
                        lock_bits[ps * NUM_KNOBS + j] = 1'b1;
                    end
                    cur_page = ps;
                end
                report_page = cur_page;
            end
            kpc_pkg::FUNC_SET:
            begin
                report_page = ps;
                if (kn < NUM_KNOBS && ps < NUM_PAGES)
                begin
                    e = ps * NUM_KNOBS + kn;
                    stored_vals[e] = reading;
                    lock_bits[e] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        r.page = kpc_pkg::PAGE_W'(cur_page);
        r.knob = knob;
        if (kn < NUM_KNOBS && report_page < NUM_PAGES)
        begin
            e = report_page * NUM_KNOBS + kn;
            r.value = stored_vals[e];
            r.locked = lock_bits[e];
        end
        else
        begin
            r.value = '0;
            r.locked = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        pickup_result_t want;
        int             i;

        if (!rst_n)
        begin
            for (i = 0; i < ENTRIES; i++)
            begin
                stored_vals[i] = '0;
                last_reads[i] = '0;
                lock_bits[i] = 1'b1;
            end
            cur_page = 0;
            catch_window = kpc_pkg::WINDOW_RESET;
            pending_results.delete();
            results_seen = 0;
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                catch_window = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                pending_results.push_back(takeover_step(func, knob_index, page_select,
                                                        knob_value));
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    flag_mismatch("beat with nothing pending, stored_value",
                                  int'(stored_value), 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_page !== want.page)
                    begin
                        flag_mismatch("out_page", int'(out_page), int'(want.page));
                    end
                    if (out_knob !== want.knob)
                    begin
                        flag_mismatch("out_knob", int'(out_knob), int'(want.knob));
                    end
                    if (applied !== want.applied)
                    begin
                        flag_mismatch("applied", int'(applied), int'(want.applied));
                    end
                    if (stored_value !== want.value)
                    begin
                        flag_mismatch("stored_value", int'(stored_value), int'(want.value));
                    end
                    if (is_locked !== want.locked)
                    begin
                        flag_mismatch("is_locked", int'(is_locked), int'(want.locked));
                    end
                end
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

FILE: sim/knob_pickup_catch_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_pickup_catch_test
// Drives knob samples, page switches and preset loads into the pickup block
// under several catch windows, with random gaps on both sides, and reports
// the verdict from the checker that sits beside the block.
// ----------------------------------------------------------------------------
module knob_pickup_catch_test;

    localparam logic [kpc_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_BEATS  = 390;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [kpc_pkg::VALUE_W-1:0] cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic [kpc_pkg::FUNC_W-1:0]  func;
    logic [kpc_pkg::KNOB_W-1:0]  knob_index;
    logic [kpc_pkg::PAGE_W-1:0]  page_select;
    logic [kpc_pkg::VALUE_W-1:0] knob_value;
    logic                        out_valid;
    logic                        out_ready;
    logic [kpc_pkg::PAGE_W-1:0]  out_page;
    logic [kpc_pkg::KNOB_W-1:0]  out_knob;
    logic                        applied;
    logic [kpc_pkg::VALUE_W-1:0] stored_value;
    logic                        is_locked;

    int   mismatches;
    int   outstanding;
    int   quiet_cycles;
    logic steady = 1'b0;
    logic [kpc_pkg::PAGE_W-1:0] shown_page = '0;
    int   beats_sent = 0;
    int   sent_samples = 0;
    int   sent_switches = 0;
    int   sent_presets = 0;
    int   sent_unused = 0;
    int   windows_written = 0;

    knob_pickup_catch uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .knob_index   (knob_index),
        .page_select  (page_select),
        .knob_value   (knob_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_page     (out_page),
        .out_knob     (out_knob),
        .applied      (applied),
        .stored_value (stored_value),
        .is_locked    (is_locked)
    );

    knob_pickup_catch_checker u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .knob_index   (knob_index),
        .page_select  (page_select),
        .knob_value   (knob_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_page     (out_page),
        .out_knob     (out_knob),
        .applied      (applied),
        .stored_value (stored_value),
        .is_locked    (is_locked),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int hold;

        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 8);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    task automatic send_beat(
        input logic [kpc_pkg::FUNC_W-1:0]  op,
        input logic [kpc_pkg::KNOB_W-1:0]  knob,
        input logic [kpc_pkg::PAGE_W-1:0]  psel,
        input logic [kpc_pkg::VALUE_W-1:0] value
    );
        int gap;

        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= op;
        knob_index <= knob;
        page_select <= psel;
        knob_value <= value;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
        case (op)
            kpc_pkg::FUNC_SAMPLE: sent_samples++;
            kpc_pkg::FUNC_SWITCH:
            begin
                sent_switches++;
                shown_page = psel;
            end
            kpc_pkg::FUNC_SET:    sent_presets++;
            default:              sent_unused++;
        endcase
    endtask

    task automatic write_window(input logic [kpc_pkg::VALUE_W-1:0] w);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        cfg_valid <= 1'b1;
        cfg_data <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        windows_written++;
    endtask

    // Moves one knob from one position to another in a few steps, with a
    // little jitter as a real potentiometer would show.
    task automatic sweep_knob(input logic [kpc_pkg::KNOB_W-1:0] knob, input int from,
                              input int to, input int steps);
        int i;
        int v;

        for (i = 0; i < steps; i++)
        begin
            v = from + ((to - from) * i) / (steps - 1) + $urandom_range(0, 128) - 64;
            if (v < 0)
            begin
                v = 0;
            end
            if (v > 65535)
            begin
                v = 65535;
            end
            send_beat(kpc_pkg::FUNC_SAMPLE, knob, kpc_pkg::PAGE_W'($urandom_range(0, 1)),
                      kpc_pkg::VALUE_W'(v));
        end
    endtask

    task automatic play_gestures(input int count);
        int stop;
        int pick;
        int target;
        logic [kpc_pkg::KNOB_W-1:0] knob;

        stop = beats_sent + count;
        while (beats_sent < stop)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                steady = !steady;
            end
            pick = $urandom_range(0, 19);
            knob = kpc_pkg::KNOB_W'($urandom_range(0, 7));
            if (pick == 0)
            begin
                send_beat(kpc_pkg::FUNC_SWITCH, knob, kpc_pkg::PAGE_W'($urandom_range(0, 1)),
                          kpc_pkg::VALUE_W'($urandom));
            end
            else if (pick == 1)
            begin
                send_beat(kpc_pkg::FUNC_SET, knob, kpc_pkg::PAGE_W'($urandom_range(0, 1)),
                          kpc_pkg::VALUE_W'($urandom));
            end
            else if (pick == 2)
            begin
                send_beat(FUNC_UNUSED, knob, kpc_pkg::PAGE_W'($urandom_range(0, 1)),
                          kpc_pkg::VALUE_W'($urandom));
            end
            else if (pick == 3)
            begin
                send_beat(kpc_pkg::FUNC_SAMPLE, knob, kpc_pkg::PAGE_W'($urandom_range(0, 1)),
                          kpc_pkg::VALUE_W'($urandom));
            end
            else if (pick <= 7)
            begin
                sweep_knob(knob, $urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(2, 10));
            end
            else
            begin
                // A preset load on the shown page, then the player reaching for it.
                target = $urandom_range(0, 65535);
                send_beat(kpc_pkg::FUNC_SET, knob, shown_page, kpc_pkg::VALUE_W'(target));
                sweep_knob(knob, $urandom_range(0, 65535),
                           target + $urandom_range(0, 6000) - 3000, $urandom_range(3, 12));
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        func <= kpc_pkg::FUNC_SAMPLE;
        knob_index <= '0;
        page_select <= '0;
        knob_value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(kpc_pkg::FUNC_SAMPLE, 3'd0, 1'b0, 16'h0000);
        send_beat(kpc_pkg::FUNC_SAMPLE, 3'd0, 1'b1, 16'hFFFF);
        send_beat(kpc_pkg::FUNC_SAMPLE, 3'd0, 1'b0, 16'h0000);
        send_beat(kpc_pkg::FUNC_SET, 3'd2, 1'b0, 16'h8000);
        send_beat(kpc_pkg::FUNC_SAMPLE, 3'd2, 1'b0, 16'h1000);
        send_beat(kpc_pkg::FUNC_SAMPLE, 3'd2, 1'b0, 16'h7C00);
        send_beat(kpc_pkg::FUNC_SET, 3'd3, 1'b0, 16'h4000);
        send_beat(kpc_pkg::FUNC_SAMPLE, 3'd3, 1'b0, 16'h2000);
        send_beat(kpc_pkg::FUNC_SAMPLE, 3'd3, 1'b0, 16'h6000);
        send_beat(kpc_pkg::FUNC_SET, 3'd7, 1'b1, 16'hFFFF);
        send_beat(kpc_pkg::FUNC_SWITCH, 3'd5, 1'b1, 16'h0000);
        send_beat(kpc_pkg::FUNC_SAMPLE, 3'd7, 1'b0, 16'h0000);
        send_beat(kpc_pkg::FUNC_SAMPLE, 3'd7, 1'b1, 16'hFFFF);
        send_beat(kpc_pkg::FUNC_SAMPLE, 3'd7, 1'b0, 16'h0001);
        send_beat(FUNC_UNUSED, 3'd4, 1'b1, 16'hA5A5);
        send_beat(kpc_pkg::FUNC_SET, 3'd0, 1'b0, 16'h1234);
        send_beat(kpc_pkg::FUNC_SWITCH, 3'd0, 1'b0, 16'h5A5A);
        send_beat(kpc_pkg::FUNC_SAMPLE, 3'd0, 1'b0, 16'h1234);
        send_beat(kpc_pkg::FUNC_SAMPLE, 3'd6, 1'b1, 16'hFFFF);

        write_window(16'd0);
        play_gestures(PHASE_BEATS);
        write_window(16'hFFFF);
        play_gestures(PHASE_BEATS);
        write_window(kpc_pkg::VALUE_W'($urandom_range(1, 65534)));
        play_gestures(PHASE_BEATS);
        write_window(16'd1);
        play_gestures(PHASE_BEATS);
        write_window(kpc_pkg::WINDOW_RESET);
        play_gestures(PHASE_BEATS);

        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);

        $display("Run covered %0d beats: %0d samples, %0d page switches, %0d preset loads,",
                 beats_sent, sent_samples, sent_switches, sent_presets);
        $display("%0d unused codes, under %0d catch window settings from 0 to 65535.",
                 sent_unused, windows_written + 1);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
